@@ rtl/pwis_pkg.sv @@
package pwis_pkg;

	localparam int BUFFER_BYTES = 128;
	localparam int CNT_W        = 8;
	localparam int IDLE_W       = 17;
	localparam int PERIOD_W     = 12;
	localparam int PLEN_W       = 6;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;

	localparam logic [7:0]          ECHO_REQUEST   = 8'd8;
	localparam logic [CNT_W-1:0]    MIN_HEADER     = 8'd20;
	localparam logic [3:0]          IPV4_VERSION   = 4'd4;
	localparam logic [IDLE_W-1:0]   IDLE_MAX       = '1;
	localparam logic [PERIOD_W-1:0] CHECK_MAX      = '1;
	localparam logic [PLEN_W-1:0]   PLEN_MAX       = 6'd32;

	localparam logic [31:0]         SUBNET_RST     = 32'h0A64_0000;
	localparam logic [PLEN_W-1:0]   PLEN_RST       = 6'd24;
	localparam logic [IDLE_W-1:0]   TIMEOUT_RST    = 17'd1800;
	localparam logic [PERIOD_W-1:0] PERIOD_RST     = 12'd60;

	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_ADDR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUBNET_PLEN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TMO    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PER   = 8'd3;

	typedef enum logic [1:0] {
		ACT_BYTE    = 2'd0,
		ACT_TICK    = 2'd1,
		ACT_SESSION = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  packet_byte;
		logic        last_byte;
		logic [31:0] source_address;
		logic        server_running;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]        command;
		logic              ping_accepted;
		logic [IDLE_W-1:0] idle_seconds_now;
	} out_beat_t;

	// Control from the top level to the idle watchdog for one accepted beat.
	typedef struct packed {
		logic step;
		logic tick;
		logic session;
		logic ping_ok;
		logic running;
	} idle_ctl_t;

endpackage

@@ rtl/pwis_pkt.sv @@
module pwis_pkt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_en,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic [31:0] source_address,
	input  logic [31:0] subnet_address,
	input  logic [pwis_pkg::PLEN_W-1:0] subnet_plen,
	output logic        ping_ok
);

	logic [pwis_pkg::CNT_W-1:0] bytes_seen_q;
	logic [7:0]                 first_q;
	logic [7:0]                 type_q;

	logic [pwis_pkg::CNT_W-1:0] bytes_next;
	logic [7:0]                 first_next;
	logic [7:0]                 type_next;
	logic [7:0]                 b0;
	logic [5:0]                 offset;
	logic [5:0]                 ihl_next;
	logic                       in_buf;
	logic                       is_ipv4;
	logic                       too_short;
	logic [7:0]                 pkt_type;
	logic [pwis_pkg::PLEN_W-1:0] plen;
	logic [31:0]                mask;
	logic                       in_subnet;

	always_comb begin
		in_buf     = bytes_seen_q < pwis_pkg::CNT_W'(pwis_pkg::BUFFER_BYTES);
		b0         = (bytes_seen_q == '0) ? packet_byte : first_q;
		offset     = {b0[3:0], 2'b00};
		bytes_next = bytes_seen_q;
		first_next = first_q;
		type_next  = type_q;
		if (in_buf) begin
			if (bytes_seen_q == '0) begin
				first_next = packet_byte;
			end
			if (bytes_seen_q == pwis_pkg::CNT_W'(offset)) begin
				type_next = packet_byte;
			end
			bytes_next = bytes_seen_q + 1'b1;
		end

		ihl_next  = {first_next[3:0], 2'b00};
		is_ipv4   = (bytes_next >= pwis_pkg::MIN_HEADER)
			&& (first_next[7:4] == pwis_pkg::IPV4_VERSION);
		too_short = is_ipv4 && (bytes_next <= pwis_pkg::CNT_W'(ihl_next));
		pkt_type  = is_ipv4 ? type_next : first_next;

		plen      = (subnet_plen > pwis_pkg::PLEN_MAX) ? pwis_pkg::PLEN_MAX : subnet_plen;
		mask      = ~(32'hFFFF_FFFF >> plen);
		in_subnet = (source_address & mask) == (subnet_address & mask);

		ping_ok = byte_en && last_byte && !too_short
			&& (pkt_type == pwis_pkg::ECHO_REQUEST) && in_subnet;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			first_q      <= '0;
			type_q       <= '0;
		end else if (byte_en) begin
			bytes_seen_q <= last_byte ? '0 : bytes_next;
			first_q      <= first_next;
			type_q       <= type_next;
		end
	end

endmodule

@@ rtl/pwis_idle.sv @@
module pwis_idle (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pwis_pkg::idle_ctl_t            ctl,
	input  logic [pwis_pkg::IDLE_W-1:0]    idle_timeout,
	input  logic [pwis_pkg::PERIOD_W-1:0]  check_period,
	output logic                           stop,
	output logic [pwis_pkg::IDLE_W-1:0]    idle_next
);

	logic [pwis_pkg::IDLE_W-1:0]   idle_q;
	logic [pwis_pkg::PERIOD_W-1:0] check_q;
	logic [pwis_pkg::PERIOD_W-1:0] check_next;
	logic [pwis_pkg::PERIOD_W-1:0] period;
	logic [pwis_pkg::IDLE_W-1:0]   idle_inc;
	logic [pwis_pkg::PERIOD_W-1:0] check_inc;

	always_comb begin
		period    = (check_period == '0) ? pwis_pkg::PERIOD_W'(1) : check_period;
		idle_inc  = (idle_q < pwis_pkg::IDLE_MAX) ? idle_q + 1'b1 : idle_q;
		check_inc = (check_q < pwis_pkg::CHECK_MAX) ? check_q + 1'b1 : check_q;
		idle_next  = idle_q;
		check_next = check_q;
		stop       = 1'b0;
		priority if (ctl.tick) begin
			idle_next = idle_inc;
			if (check_inc >= period) begin
				check_next = '0;
				stop       = ctl.running && (idle_inc >= idle_timeout);
			end else begin
				check_next = check_inc;
			end
		end else if (ctl.session || ctl.ping_ok) begin
			idle_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= '0;
			check_q <= '0;
		end else if (ctl.step) begin
			idle_q  <= idle_next;
			check_q <= check_next;
		end
	end

endmodule

@@ rtl/ping_wake_idle_shutdown_core.sv @@
// An accepted input beat's result beat is registered in the output register.
// Throughput: one beat per cycle when no result is held or the held one is being taken.
// All per-beat work is a compare-and-capture in the packet tracker and counter updates.
// Reset (arst_n low, asynchronous) clears packet state, idle and check counters and the
// output valid flag, and loads the configuration registers with their defaults.
module ping_wake_idle_shutdown_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pwis_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pwis_pkg::out_beat_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwis_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [31:0]                   subnet_q;
	logic [pwis_pkg::PLEN_W-1:0]   plen_q;
	logic [pwis_pkg::IDLE_W-1:0]   timeout_q;
	logic [pwis_pkg::PERIOD_W-1:0] period_q;

	logic                          out_valid_q;
	pwis_pkg::out_beat_t           out_data_q;

	logic                          step;
	logic                          ping_ok;
	logic                          stop;
	logic [pwis_pkg::IDLE_W-1:0]   idle_next;
	pwis_pkg::idle_ctl_t           idle_ctl;
	pwis_pkg::out_beat_t           result;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subnet_q  <= pwis_pkg::SUBNET_RST;
			plen_q    <= pwis_pkg::PLEN_RST;
			timeout_q <= pwis_pkg::TIMEOUT_RST;
			period_q  <= pwis_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pwis_pkg::REG_SUBNET_ADDR: subnet_q <= cfg_data;
				pwis_pkg::REG_SUBNET_PLEN: plen_q <= cfg_data[pwis_pkg::PLEN_W-1:0];
				pwis_pkg::REG_IDLE_TMO: timeout_q <= cfg_data[pwis_pkg::IDLE_W-1:0];
				pwis_pkg::REG_CHECK_PER: period_q <= cfg_data[pwis_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pwis_pkt u_pkt (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_en        (step && (in_data.action == pwis_pkg::ACT_BYTE)),
		.packet_byte    (in_data.packet_byte),
		.last_byte      (in_data.last_byte),
		.source_address (in_data.source_address),
		.subnet_address (subnet_q),
		.subnet_plen    (plen_q),
		.ping_ok        (ping_ok)
	);

	always_comb begin
		idle_ctl.step    = step;
		idle_ctl.tick    = in_data.action == pwis_pkg::ACT_TICK;
		idle_ctl.session = in_data.action == pwis_pkg::ACT_SESSION;
		idle_ctl.ping_ok = ping_ok;
		idle_ctl.running = in_data.server_running;
	end

	pwis_idle u_idle (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (idle_ctl),
		.idle_timeout (timeout_q),
		.check_period (period_q),
		.stop         (stop),
		.idle_next    (idle_next)
	);

	always_comb begin
		result.ping_accepted    = ping_ok;
		result.idle_seconds_now = idle_next;
		priority if (ping_ok && !in_data.server_running) begin
			result.command = pwis_pkg::CMD_START;
		end else if (stop) begin
			result.command = pwis_pkg::CMD_STOP;
		end else begin
			result.command = pwis_pkg::CMD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A start is only ever issued for an accepted ping.
	a_start_needs_ping: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.command == pwis_pkg::CMD_START) |-> out_data_q.ping_accepted)
		else $error("start command without accepted ping");

	// An accepted ping always leaves the idle count cleared.
	a_ping_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.ping_accepted |-> (out_data_q.idle_seconds_now == '0))
		else $error("accepted ping did not clear idle count");

	// A stop comes only from a tick with the idle count at or past the timeout.
	a_stop_past_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		step && stop |=> out_valid_q && (out_data_q.command == pwis_pkg::CMD_STOP)
			&& (out_data_q.idle_seconds_now >= timeout_q))
		else $error("stop command below idle timeout");

endmodule
